>>> rtl/som_pkg.sv
`timescale 1ns / 1ps
// Package for the slot occupancy map: grid size, derived widths, action codes
// and the result record passed from the sequencer to the output stage.
// Depends on nothing.
package som_pkg;

   localparam int COLUMNS = 6;
   localparam int ROWS    = 6;
   localparam int TOTAL   = COLUMNS * ROWS;

   localparam int IDX_W = (TOTAL > 1) ? $clog2(TOTAL) : 1;
   localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int CNT_W = $clog2(TOTAL + 1);

   typedef enum logic [2:0] {
      ACT_QUERY     = 3'd0,
      ACT_SET       = 3'd1,
      ACT_CLEAR     = 3'd2,
      ACT_TOGGLE    = 3'd3,
      ACT_CLEAR_ALL = 3'd4,
      ACT_FILL_ALL  = 3'd5,
      ACT_FIND_FREE = 3'd6,
      ACT_FIND_OCC  = 3'd7
   } action_type;

   typedef struct packed {
      logic             ok;
      logic             occupied;
      logic [3:0]       found_column;
      logic [3:0]       found_row;
      logic [CNT_W-1:0] count;
   } result_type;

endpackage

>>> rtl/som_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module som_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 36
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/som_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the slot occupancy map: one index counter and bit compare unit
// stepped over the grid memory for slot updates, sweeps and searches.
// Depends on som_pkg.
module som_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [2:0]                       req_action,
   input  logic [3:0]                       req_column,
   input  logic [3:0]                       req_row,
   input  logic                             out_free,
   output logic                             res_valid,
   output som_pkg::result_type              res,
   output logic                             mem_wr_en,
   output logic [som_pkg::IDX_W-1:0]        mem_addr,
   output logic                             mem_wr_data,
   input  logic                             mem_rd_data
);

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ,
      ST_APPLY,
      ST_SWEEP,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_DONE
   } state_type;

   localparam logic [som_pkg::IDX_W-1:0] LAST_IDX = som_pkg::IDX_W'(som_pkg::TOTAL - 1);
   localparam logic [som_pkg::ROW_W-1:0] LAST_ROW = som_pkg::ROW_W'(som_pkg::ROWS - 1);

   state_type                     state_ff, state_in;
   som_pkg::action_type           act_ff, act_in;
   logic [som_pkg::IDX_W-1:0]     idx_ff, idx_in;
   logic [som_pkg::COL_W-1:0]     scol_ff, scol_in;
   logic [som_pkg::ROW_W-1:0]     srow_ff, srow_in;
   logic [som_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   logic                          ok_ff, ok_in;
   logic                          occ_ff, occ_in;
   logic [3:0]                    fcol_ff, fcol_in;
   logic [3:0]                    frow_ff, frow_in;

   som_pkg::action_type           req_act;
   logic                          slot_valid;
   logic [som_pkg::IDX_W-1:0]     slot_idx;
   logic                          new_bit;
   logic                          hit;
   logic                          idx_last;
   logic [som_pkg::IDX_W-1:0]     idx_next;

   assign req_act    = som_pkg::action_type'(req_action);
   assign slot_valid = (req_column < 4'(som_pkg::COLUMNS)) && (req_row < 4'(som_pkg::ROWS));
   assign slot_idx   = som_pkg::IDX_W'(req_column * som_pkg::ROWS + req_row);
   assign idx_last   = (idx_ff == LAST_IDX);
   assign idx_next   = idx_ff + 1'b1;
   assign hit        = (act_ff == som_pkg::ACT_FIND_OCC) ? mem_rd_data : !mem_rd_data;

   always_comb begin
      unique case (act_ff)
         som_pkg::ACT_SET:    new_bit = 1'b1;
         som_pkg::ACT_CLEAR:  new_bit = 1'b0;
         som_pkg::ACT_TOGGLE: new_bit = !mem_rd_data;
         default:             new_bit = mem_rd_data;
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      act_in      = act_ff;
      idx_in      = idx_ff;
      scol_in     = scol_ff;
      srow_in     = srow_ff;
      cnt_in      = cnt_ff;
      ok_in       = ok_ff;
      occ_in      = occ_ff;
      fcol_in     = fcol_ff;
      frow_in     = frow_ff;
      req_ready   = 1'b0;
      res_valid   = 1'b0;
      mem_wr_en   = 1'b0;
      mem_wr_data = 1'b0;

      unique case (state_ff)
         ST_INIT: begin
            mem_wr_en = 1'b1;
            idx_in    = idx_next;
            if (idx_last) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               act_in  = req_act;
               ok_in   = 1'b0;
               occ_in  = 1'b0;
               fcol_in = '0;
               frow_in = '0;
               idx_in  = '0;
               scol_in = '0;
               srow_in = '0;
               unique case (req_act)
                  som_pkg::ACT_CLEAR_ALL, som_pkg::ACT_FILL_ALL: begin
                     state_in = ST_SWEEP;
                  end
                  som_pkg::ACT_FIND_FREE, som_pkg::ACT_FIND_OCC: begin
                     state_in = ST_SCAN_RD;
                  end
                  default: begin
                     if (slot_valid) begin
                        idx_in   = slot_idx;
                        state_in = ST_READ;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            ok_in       = 1'b1;
            occ_in      = new_bit;
            mem_wr_en   = (new_bit != mem_rd_data);
            mem_wr_data = new_bit;
            if (new_bit && !mem_rd_data) begin
               cnt_in = cnt_ff + 1'b1;
            end else if (!new_bit && mem_rd_data) begin
               cnt_in = cnt_ff - 1'b1;
            end
            state_in = ST_DONE;
         end
         ST_SWEEP: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = (act_ff == som_pkg::ACT_FILL_ALL);
            idx_in      = idx_next;
            if (idx_last) begin
               ok_in    = 1'b1;
               cnt_in   = (act_ff == som_pkg::ACT_FILL_ALL) ?
                          som_pkg::CNT_W'(som_pkg::TOTAL) : '0;
               state_in = ST_DONE;
            end
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            if (hit) begin
               ok_in    = 1'b1;
               occ_in   = mem_rd_data;
               fcol_in  = 4'(scol_ff);
               frow_in  = 4'(srow_ff);
               state_in = ST_DONE;
            end else if (idx_last) begin
               state_in = ST_DONE;
            end else begin
               idx_in = idx_next;
               if (srow_ff == LAST_ROW) begin
                  srow_in = '0;
                  scol_in = scol_ff + 1'b1;
               end else begin
                  srow_in = srow_ff + 1'b1;
               end
               state_in = ST_SCAN_RD;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               res_valid = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         idx_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         cnt_ff   <= cnt_in;
      end
      act_ff  <= act_in;
      scol_ff <= scol_in;
      srow_ff <= srow_in;
      ok_ff   <= ok_in;
      occ_ff  <= occ_in;
      fcol_ff <= fcol_in;
      frow_ff <= frow_in;
   end

   assign mem_addr         = idx_ff;
   assign res.ok           = ok_ff;
   assign res.occupied     = occ_ff;
   assign res.found_column = fcol_ff;
   assign res.found_row    = frow_ff;
   assign res.count        = cnt_ff;

endmodule

>>> rtl/slot_occupancy_map_top.sv
`timescale 1ns / 1ps
// Top level of the slot occupancy map: sequencer, grid memory and output register.
// Depends on som_pkg, som_ram and som_ctrl.
//
// Usage. The block keeps a COLUMNS by ROWS grid of occupied bits in a small RAM,
// one bit per slot, plus a register holding the number of occupied slots.
// A request transfer (req_valid/req_ready) carries an action, a column and a row;
// each request gives exactly one response transfer (rsp_valid/rsp_ready) with the
// status of the named or found slot and the occupied and empty totals.
// Timing is set by the one index counter and bit compare unit that walks the grid
// RAM, whose read port is registered. A slot action (query, set, clear, toggle)
// reads the slot and then writes the new bit if it changed; an out-of-range slot
// goes straight to the response; clear all and fill all write the grid, one write
// per slot; a search reads and checks each slot in turn until it finds a match or
// has checked the last slot. req_ready rises again in the cycle that rsp_valid rises.
// req_ready is high only while the sequencer is idle, so one request is in work
// at a time. The response sits in an output register; the next request is taken
// while it waits, and that request's response is held back until rsp_ready drains
// the register, so a stalled receiver stops the block without loss.
// After reset the sequencer clears all TOTAL slots of the grid RAM, one slot a
// cycle (36 slots for the 6 by 6 grid), before req_ready rises.
module slot_occupancy_map_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_action,
   input  logic [3:0] req_column,
   input  logic [3:0] req_row,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_ok,
   output logic       rsp_slot_occupied,
   output logic [3:0] rsp_found_column,
   output logic [3:0] rsp_found_row,
   output logic [6:0] rsp_occupied_total,
   output logic [6:0] rsp_empty_total,
   output logic       rsp_all_full,
   output logic       rsp_all_empty
);

   som_pkg::result_type             res;
   logic                            res_valid;
   logic                            out_free;
   logic                            mem_wr_en;
   logic [som_pkg::IDX_W-1:0]       mem_addr;
   logic                            mem_wr_data;
   logic                            mem_rd_data;

   logic       rsp_valid_ff, rsp_valid_in;
   logic       ok_ff;
   logic       occ_ff;
   logic [3:0] fcol_ff;
   logic [3:0] frow_ff;
   logic [6:0] occ_total_ff;
   logic [6:0] empty_total_ff;
   logic       full_ff;
   logic       empty_ff;

   // The output register may take a new result when it is empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_ready;

   som_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_action  (req_action),
      .req_column  (req_column),
      .req_row     (req_row),
      .out_free    (out_free),
      .res_valid   (res_valid),
      .res         (res),
      .mem_wr_en   (mem_wr_en),
      .mem_addr    (mem_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_data (mem_rd_data)
   );

   som_ram #(
      .WIDTH (1),
      .DEPTH (som_pkg::TOTAL)
   ) u_grid (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_addr),
      .rd_data (mem_rd_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Totals and flags are derived once, when the result is loaded.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (res_valid) begin
         ok_ff          <= res.ok;
         occ_ff         <= res.occupied;
         fcol_ff        <= res.found_column;
         frow_ff        <= res.found_row;
         occ_total_ff   <= 7'(res.count);
         empty_total_ff <= 7'(som_pkg::TOTAL) - 7'(res.count);
         full_ff        <= (res.count == som_pkg::CNT_W'(som_pkg::TOTAL));
         empty_ff       <= (res.count == '0);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_ok             = ok_ff;
   assign rsp_slot_occupied  = occ_ff;
   assign rsp_found_column   = fcol_ff;
   assign rsp_found_row      = frow_ff;
   assign rsp_occupied_total = occ_total_ff;
   assign rsp_empty_total    = empty_total_ff;
   assign rsp_all_full       = full_ff;
   assign rsp_all_empty      = empty_ff;

   // A result is never loaded over one that the receiver has not yet taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> out_free)
      else $error("result loaded over a pending response");

   // One request at a time: after a request transfer the block is busy.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while the previous one is in work");

   // The occupied count never exceeds the number of slots.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_occupied_total <= 7'(som_pkg::TOTAL)))
      else $error("occupied total out of range");

   // A search that reports an occupied slot other than column 0, row 0 never does so with a zero occupied count.
   a_found_occ: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.ok && (res.found_column != 4'd0 || res.found_row != 4'd0))
      |-> (res.count != '0 || !res.occupied))
      else $error("occupied slot found in an empty grid");

endmodule
